@@ rtl/core/kpa_pkg.sv @@
//------------------------------------------------------------------------------
// kpa_pkg
// Shared types and constants for the keyframe parameter automation block.
//------------------------------------------------------------------------------
package kpa_pkg;

    localparam int EVENTS_PER_LANE_DEF = 16;
    localparam int TIME_WIDTH_DEF      = 32;
    localparam int LANES               = 3;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_MOVE = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LANE = 2'd2;

    localparam logic [1:0] LANE_PAN  = 2'd0;
    localparam logic [1:0] LANE_PRES = 2'd1;
    localparam logic [1:0] LANE_REG  = 2'd2;
    localparam logic [1:0] LANE_NONE = 2'd3;

    localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_READ,
        OP_STEP,
        OP_EVAL,
        OP_DIV,
        OP_APPLY
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] lane;
    } kpa_cmd_t;

    typedef struct packed {
        logic has_event;
        logic can_step;
        logic started;
        logic div_done;
        logic lane_full;
    } kpa_sts_t;

    function automatic logic signed [15:0] clamp_lane(input logic [1:0] lane,
                                                      input logic signed [16:0] v);
        logic signed [16:0] r;
        r = v;
        if (r > ONE_Q14) r = ONE_Q14;
        if (lane == LANE_PAN && r < -ONE_Q14) r = -ONE_Q14;
        if (lane == LANE_REG && r < 17'sd0) r = 17'sd0;
        if (r < -17'sd32768) r = -17'sd32768;
        return r[15:0];
    endfunction

endpackage

@@ rtl/core/kpa_datapath.sv @@
//------------------------------------------------------------------------------
// kpa_datapath
// Event memory, lane counters, cursor walk, serial divider and level clamp.
//------------------------------------------------------------------------------
module kpa_datapath #(
    parameter int EVENTS_PER_LANE = kpa_pkg::EVENTS_PER_LANE_DEF,
    parameter int TIME_WIDTH      = kpa_pkg::TIME_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  kpa_pkg::kpa_cmd_t        cmd,
    output kpa_pkg::kpa_sts_t        sts,
    input  logic [1:0]               in_mode,
    input  logic signed [15:0]       in_va,
    input  logic signed [15:0]       in_vb,
    input  logic [TIME_WIDTH-1:0]    in_ta,
    input  logic [TIME_WIDTH-1:0]    in_tb,
    output logic signed [15:0]       pan_level,
    output logic signed [15:0]       pres_level,
    output logic [14:0]              reg_level
);
    import kpa_pkg::*;

    localparam int CW    = $clog2(EVENTS_PER_LANE + 1);
    localparam int DEPTH = LANES * EVENTS_PER_LANE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = 17 + TIME_WIDTH;
    localparam int DCW   = $clog2(NW + 1);

    typedef struct packed {
        logic                  is_move;
        logic signed [15:0]    v0;
        logic signed [15:0]    v1;
        logic [TIME_WIDTH-1:0] t0;
        logic [TIME_WIDTH-1:0] t1;
    } evt_t;

    evt_t mem [DEPTH];
    evt_t rd_reg;
    evt_t nx_reg;

    logic [CW-1:0] count_reg  [LANES];
    logic [CW-1:0] cursor_reg [LANES];
    logic signed [15:0] level_reg [LANES];

    logic [CW-1:0] cur_reg;
    logic signed [16:0] result_reg;
    logic neg_reg;
    logic [NW-1:0] num_reg;
    logic [TIME_WIDTH-1:0] den_reg;
    logic [NW-1:0] quo_reg;
    logic [TIME_WIDTH:0] rem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic ddone_reg;

    logic [1:0] ln;
    logic [AW-1:0] wr_addr, rd_addr, nx_addr;
    logic [CW-1:0] cnt_l, cur_l;
    logic signed [16:0] delta;
    logic [16:0] mag;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [TIME_WIDTH:0] rem_sh;

    assign ln    = cmd.lane;
    assign cnt_l = count_reg[ln];
    assign cur_l = cursor_reg[ln];
    assign wr_addr = AW'(ln * EVENTS_PER_LANE + cnt_l);
    assign rd_addr = AW'(ln * EVENTS_PER_LANE + cur_reg);
    assign nx_addr = AW'(ln * EVENTS_PER_LANE + cur_reg + 1);
    assign delta   = 17'(rd_reg.v1) - 17'(rd_reg.v0);
    assign mag     = delta[16] ? 17'(-delta) : 17'(delta);
    assign elapsed = in_ta - rd_reg.t0;
    assign rem_sh  = {rem_reg[TIME_WIDTH-1:0], num_reg[NW-1]};

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_APPEND && in_mode != MODE_TICK) begin
            mem[wr_addr] <= '{in_mode == MODE_MOVE, in_va,
                              (in_mode == MODE_MOVE) ? in_vb : 16'sd0, in_ta,
                              (in_mode == MODE_MOVE) ? in_tb : '0};
        end
        rd_reg <= mem[rd_addr];
        nx_reg <= mem[nx_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                count_reg[i]  <= '0;
                cursor_reg[i] <= '0;
            end
            level_reg[0] <= 16'sd0;
            level_reg[1] <= 16'sd8192;
            level_reg[2] <= 16'sd8192;
            ddone_reg    <= 1'b0;
            dcnt_reg     <= '0;
            cur_reg      <= '0;
        end else begin
            unique case (cmd.op)
                OP_APPEND: begin
                    count_reg[ln] <= cnt_l + 1'b1;
                end
                OP_READ: begin
                    cur_reg   <= cur_l;
                    ddone_reg <= 1'b0;
                end
                OP_STEP: begin
                    cur_reg <= cur_reg + 1'b1;
                end
                OP_EVAL: begin
                    if (!rd_reg.is_move) begin
                        result_reg <= 17'(rd_reg.v0);
                        ddone_reg  <= 1'b1;
                    end else if (in_ta >= rd_reg.t1) begin
                        result_reg <= 17'(rd_reg.v1);
                        ddone_reg  <= 1'b1;
                    end else begin
                        neg_reg  <= delta[16];
                        num_reg  <= NW'(mag) * NW'(elapsed);
                        den_reg  <= rd_reg.t1 - rd_reg.t0;
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        dcnt_reg <= DCW'(NW);
                    end
                end
                OP_DIV: begin
                    if (dcnt_reg != '0) begin
                        num_reg <= num_reg << 1;
                        if (rem_sh >= {1'b0, den_reg}) begin
                            rem_reg <= rem_sh - {1'b0, den_reg};
                            quo_reg <= {quo_reg[NW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[NW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end else begin
                        result_reg <= neg_reg ? 17'(rd_reg.v0) - 17'(quo_reg)
                                              : 17'(rd_reg.v0) + 17'(quo_reg);
                        ddone_reg  <= 1'b1;
                    end
                end
                OP_APPLY: begin
                    level_reg[ln] <= clamp_lane(ln, result_reg);
                    if (!rd_reg.is_move || rd_reg.t1 < in_ta) begin
                        cursor_reg[ln] <= cur_reg + 1'b1;
                    end else begin
                        cursor_reg[ln] <= cur_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sts.lane_full  = (cnt_l >= CW'(EVENTS_PER_LANE));
        sts.has_event  = (cur_l < cnt_l);
        sts.can_step   = (cur_reg + 1'b1 < cnt_l) && (in_ta >= nx_reg.t0);
        sts.started    = (in_ta >= rd_reg.t0);
        sts.div_done   = ddone_reg;
    end

    assign pan_level  = level_reg[0];
    assign pres_level = level_reg[1];
    assign reg_level  = level_reg[2][14:0];

    property p_append_room;
        @(posedge aclk) disable iff (!aresetn)
            (cmd.op == OP_APPEND) |-> (cnt_l < CW'(EVENTS_PER_LANE));
    endproperty
    a_append_room: assert property (p_append_room) else $error("append into full lane");

    property p_cursor_bound;
        @(posedge aclk) disable iff (!aresetn)
            cursor_reg[0] <= count_reg[0] && cursor_reg[1] <= count_reg[1]
            && cursor_reg[2] <= count_reg[2];
    endproperty
    a_cursor_bound: assert property (p_cursor_bound) else $error("cursor past count");

    property p_reg_range;
        @(posedge aclk) disable iff (!aresetn)
            level_reg[2] >= 16'sd0 && level_reg[2] <= 16'sd16384
            && level_reg[0] >= -16'sd16384 && level_reg[0] <= 16'sd16384;
    endproperty
    a_reg_range: assert property (p_reg_range) else $error("level out of range");

    property p_div_count;
        @(posedge aclk) disable iff (!aresetn)
            (cmd.op == OP_DIV && dcnt_reg != '0) |=> dcnt_reg == $past(dcnt_reg) - 1'b1;
    endproperty
    a_div_count: assert property (p_div_count) else $error("divider count slip");

endmodule

@@ rtl/core/kpa_ctrl.sv @@
//------------------------------------------------------------------------------
// kpa_ctrl
// Sequencer: accepts a beat, runs the append for a set or move, the three lane
// walks for a tick or neither for a no-op, and holds the result beat until it is taken.
//------------------------------------------------------------------------------
module kpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_mode,
    input  logic [1:0]         in_lane,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output kpa_pkg::kpa_cmd_t  cmd,
    input  kpa_pkg::kpa_sts_t  sts
);
    import kpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_LANE, S_WAIT, S_WALK, S_EVAL, S_DIV, S_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] mode_reg, lane_reg, cl_reg, status_reg;
    logic       ovalid_reg;

    assign in_ready   = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid  = ovalid_reg;
    assign out_status = status_reg;

    always_comb begin
        cmd.lane = (state_reg == S_ADD) ? lane_reg : cl_reg;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            S_ADD:  cmd.op = (lane_reg != LANE_NONE && !sts.lane_full) ? OP_APPEND : OP_NONE;
            S_LANE: cmd.op = sts.has_event ? OP_READ : OP_NONE;
            S_WALK: cmd.op = sts.can_step ? OP_STEP : OP_NONE;
            S_EVAL: cmd.op = sts.started ? OP_EVAL : OP_NONE;
            S_DIV:  cmd.op = sts.div_done ? OP_APPLY : OP_DIV;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            cl_reg     <= '0;
            status_reg <= ST_OK;
        end else begin
            if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        mode_reg   <= in_mode;
                        lane_reg   <= in_lane;
                        cl_reg     <= '0;
                        status_reg <= ST_OK;
                        if (in_mode == MODE_TICK) state_reg <= S_LANE;
                        else if (in_mode == MODE_SET || in_mode == MODE_MOVE)
                            state_reg <= S_ADD;
                        else state_reg <= S_DONE;
                    end
                end
                S_ADD: begin
                    if (lane_reg == LANE_NONE) status_reg <= ST_LANE;
                    else if (sts.lane_full) status_reg <= ST_FULL;
                    state_reg <= S_DONE;
                end
                S_LANE: begin
                    if (sts.has_event) state_reg <= S_WAIT;
                    else if (cl_reg == LANE_REG) state_reg <= S_DONE;
                    else cl_reg <= cl_reg + 1'b1;
                end
                S_WAIT: state_reg <= S_WALK;
                S_WALK: begin
                    if (sts.can_step) state_reg <= S_WAIT;
                    else state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    if (sts.started) begin
                        state_reg <= S_DIV;
                    end else if (cl_reg == LANE_REG) begin
                        state_reg <= S_DONE;
                    end else begin
                        cl_reg    <= cl_reg + 1'b1;
                        state_reg <= S_LANE;
                    end
                end
                S_DIV: begin
                    if (sts.div_done) begin
                        if (cl_reg == LANE_REG) state_reg <= S_DONE;
                        else begin
                            cl_reg    <= cl_reg + 1'b1;
                            state_reg <= S_LANE;
                        end
                    end
                end
                S_DONE: begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
            (ovalid_reg && !out_ready) |=> ovalid_reg && $stable(status_reg);
    endproperty
    a_hold: assert property (p_hold) else $error("result beat dropped");

    property p_busy;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg != S_IDLE) |-> !in_ready;
    endproperty
    a_busy: assert property (p_busy) else $error("ready while busy");

    property p_mode;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == S_ADD) |-> (mode_reg == MODE_SET || mode_reg == MODE_MOVE);
    endproperty
    a_mode: assert property (p_mode) else $error("add with tick mode");

endmodule

@@ rtl/core/keyframe_parameter_automation_top.sv @@
//------------------------------------------------------------------------------
// keyframe_parameter_automation_top
// Three automation lanes of set and linear move events, reporting levels.
//------------------------------------------------------------------------------
// An add beat passes through the add and done states before its result beat is
// raised; the next beat is accepted only once the result beat has been taken.
// A tick walks each lane in turn: it reads the lane's current event, steps past
// later events whose start time has come, and evaluates the event, running the
// serial divider for a move in progress. One beat is in flight.
// Synchronous reset clears counts and cursors and sets the default levels.
//------------------------------------------------------------------------------
module keyframe_parameter_automation_top #(
    parameter int EVENTS_PER_LANE = kpa_pkg::EVENTS_PER_LANE_DEF,
    parameter int TIME_WIDTH      = kpa_pkg::TIME_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], lane[3:2], value_first[19:4], value_second[35:20],
    // time_first[67:36], time_second[99:68]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], pan_level[17:2], presence_level[33:18], register_level[48:34]
    output logic [55:0]  m_tdata
);
    import kpa_pkg::*;

    kpa_cmd_t cmd;
    kpa_sts_t sts;
    logic [1:0] status;
    logic signed [15:0] pan, pres;
    logic [14:0] regl;

    logic [1:0]  mode_reg;
    logic signed [15:0] va_reg, vb_reg;
    logic [TIME_WIDTH-1:0] ta_reg, tb_reg;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tdata[1:0];
            va_reg   <= s_tdata[19:4];
            vb_reg   <= s_tdata[35:20];
            ta_reg   <= s_tdata[36 +: TIME_WIDTH];
            tb_reg   <= s_tdata[68 +: TIME_WIDTH];
        end
    end

    kpa_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_mode(s_tdata[1:0]), .in_lane(s_tdata[3:2]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_status(status),
        .cmd, .sts
    );

    kpa_datapath #(.EVENTS_PER_LANE(EVENTS_PER_LANE), .TIME_WIDTH(TIME_WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_mode(mode_reg), .in_va(va_reg), .in_vb(vb_reg),
        .in_ta(ta_reg), .in_tb(tb_reg),
        .pan_level(pan), .pres_level(pres), .reg_level(regl)
    );

    assign m_tdata = {7'd0, regl, pres, pan, status};

endmodule
